/* src/sdp_pkg.sv */
// ----------------------------------------------------------------------------
// sdp_pkg - shared types and constants of the divider planner
// Widths, search constants, divider lane table and the search result struct.
// ----------------------------------------------------------------------------
package sdp_pkg;

	localparam int F_W      = 31;   // target frequency
	localparam int P_W      = 35;   // f * hs
	localparam int R_W      = 33;   // remainder of the N1 search
	localparam int K_W      = 6;    // half of the even N1 candidate
	localparam int PROD_W   = 42;   // candidate DCO products
	localparam int DCO_W    = 33;
	localparam int XTAL_W   = 31;
	localparam int DEN_W    = 51;   // xtal * 1e6
	localparam int REM_W    = 52;   // divider remainder
	localparam int Q_W      = 38;   // rfreq
	localparam int LANES    = 6;
	localparam int DIV_STAGES = Q_W / 2;
	localparam int NUM_SHIFT  = 52 - Q_W;

	localparam logic [R_W-1:0]    MID_SUM_HZ = 33'd5260000000;
	localparam logic [P_W-1:0]    CAP_P      = 35'(64'd5260000000 / 64'd128);
	localparam logic [PROD_W-1:0] DCO_MIN_HZ = 42'd4850000000;
	localparam logic [PROD_W-1:0] DCO_MAX_HZ = 42'd5670000000;
	localparam logic [DEN_W-1:0]  XTAL_SCALE = 51'd1000000;
	localparam logic [DEN_W-1:0]  DEN_RESET  = 51'(64'd1917384130 * 64'd1000000);

	typedef struct packed {
		logic             found;
		logic [2:0]       code;
		logic [6:0]       n1_code;
		logic [DCO_W-1:0] dco;
	} srch_t;

	// lanes in search order: codes 7,5,3,2,1,0
	function automatic logic [2:0] lane_code(input int l);
		logic [2:0] c;
		unique case (l)
			0: c = 3'd7;
			1: c = 3'd5;
			2: c = 3'd3;
			3: c = 3'd2;
			4: c = 3'd1;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] lane_hs(input int l);
		logic [3:0] h;
		unique case (l)
			0: h = 4'd11;
			1: h = 4'd9;
			2: h = 4'd7;
			3: h = 4'd6;
			4: h = 4'd5;
			default: h = 4'd4;
		endcase
		return h;
	endfunction

endpackage

/* src/sdp_req_if.sv */
// ----------------------------------------------------------------------------
// sdp_req_if - request channel
// Carries the target frequency item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdp_req_if import sdp_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [F_W-1:0] target_hz;

	modport source (output valid, output target_hz, input ready);
	modport sink   (input valid, input target_hz, output ready);
endinterface

/* src/sdp_rsp_if.sv */
// ----------------------------------------------------------------------------
// sdp_rsp_if - result channel
// Carries the divider plan item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdp_rsp_if import sdp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [2:0]       hs_div_code;
	logic [6:0]       n1_code;
	logic [DCO_W-1:0] dco_hz;
	logic [Q_W-1:0]   rfreq;

	modport source (output valid, output found, output hs_div_code, output n1_code,
		output dco_hz, output rfreq, input ready);
	modport sink   (input valid, input found, input hs_div_code, input n1_code,
		input dco_hz, input rfreq, output ready);
endinterface

/* src/sdp_n1_search.sv */
// ----------------------------------------------------------------------------
// sdp_n1_search - divider candidate search
// Six divider lanes, N1 found by shift-subtract over three stages, then
// priority select of the first DCO product in range.
// ----------------------------------------------------------------------------
module sdp_n1_search import sdp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [F_W-1:0] target_hz,
	output logic           out_valid,
	output srch_t          res
);

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [P_W-1:0]       p_s1[LANES], p_s2[LANES], p_s3[LANES], p_s4[LANES];
	logic [R_W-1:0]       rem_s1[LANES], rem_s2[LANES], rem_s3[LANES], rem_s4[LANES];
	logic [K_W-1:0]       k_s1[LANES], k_s2[LANES], k_s3[LANES], k_s4[LANES];
	logic                 cap_s1[LANES], cap_s2[LANES], cap_s3[LANES], cap_s4[LANES];
	logic [R_W+K_W-1:0]   nx2[LANES], nx3[LANES], nx4[LANES];
	logic [P_W-1:0]       p_c[LANES];
	srch_t                sel_c, res_s5;

	// two quotient bits of the even-N1 search, returns {k, rem}
	function automatic logic [R_W+K_W-1:0] div_pair(input logic [R_W-1:0] r_in,
		input logic [K_W-1:0] k_in, input logic [P_W-1:0] p, input int hi);
		logic [R_W-1:0]    r;
		logic [K_W-1:0]    k;
		logic [PROD_W-1:0] t;
		r = r_in;
		k = k_in;
		for (int b = hi; b > hi - 2; b--) begin
			t = PROD_W'(p) << (b + 1);
			if (t <= PROD_W'(r)) begin
				r    = r - R_W'(t);
				k[b] = 1'b1;
			end
		end
		return {k, r};
	endfunction

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			p_c[l] = P_W'(target_hz) * P_W'(lane_hs(l));
			nx2[l] = div_pair(rem_s1[l], k_s1[l], p_s1[l], 5);
			nx3[l] = div_pair(rem_s2[l], k_s2[l], p_s2[l], 3);
			nx4[l] = div_pair(rem_s3[l], k_s3[l], p_s3[l], 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				p_s1[l]   <= p_c[l];
				rem_s1[l] <= MID_SUM_HZ;
				k_s1[l]   <= '0;
				cap_s1[l] <= (p_c[l] <= CAP_P);   // N1 would reach 128
				p_s2[l]   <= p_s1[l];
				cap_s2[l] <= cap_s1[l];
				{k_s2[l], rem_s2[l]} <= nx2[l];
				p_s3[l]   <= p_s2[l];
				cap_s3[l] <= cap_s2[l];
				{k_s3[l], rem_s3[l]} <= nx3[l];
				p_s4[l]   <= p_s3[l];
				cap_s4[l] <= cap_s3[l];
				{k_s4[l], rem_s4[l]} <= nx4[l];
			end
			res_s5 <= sel_c;
		end
	end

	// products come from the remainder: n1*p = C - rem
	always_comb begin
		logic [PROD_W-1:0] pr1, pr2, pr3;
		logic [7:0]        n2;
		logic              h1, h2, h3;
		sel_c = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			pr1 = PROD_W'(p_s4[l]);
			pr2 = cap_s4[l] ? (PROD_W'(p_s4[l]) << 7)
			                : PROD_W'(MID_SUM_HZ - rem_s4[l]);
			pr3 = PROD_W'(MID_SUM_HZ - rem_s4[l]) + (PROD_W'(p_s4[l]) << 1);
			n2  = cap_s4[l] ? 8'd128 : {1'b0, k_s4[l], 1'b0};
			h1  = (pr1 >= DCO_MIN_HZ) && (pr1 <= DCO_MAX_HZ);
			h2  = (pr2 >= DCO_MIN_HZ) && (pr2 <= DCO_MAX_HZ);
			h3  = !cap_s4[l] && (pr3 >= DCO_MIN_HZ) && (pr3 <= DCO_MAX_HZ);
			priority if (h1) begin
				sel_c = '{1'b1, lane_code(l), 7'd0, DCO_W'(pr1)};
			end else if (h2) begin
				sel_c = '{1'b1, lane_code(l), 7'(n2 - 8'd1), DCO_W'(pr2)};
			end else if (h3) begin
				sel_c = '{1'b1, lane_code(l), 7'(n2 + 8'd1), DCO_W'(pr3)};
			end
		end
	end

	assign out_valid = v_s5;
	assign res       = res_s5;

endmodule

/* src/sdp_rfreq_div.sv */
// ----------------------------------------------------------------------------
// sdp_rfreq_div - pipelined RFREQ divider
// Overflow check, then restoring division two quotient bits per stage.
// ----------------------------------------------------------------------------
module sdp_rfreq_div import sdp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  srch_t            in_res,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output srch_t            out_res,
	output logic [Q_W-1:0]   rfreq
);

	logic             v_s[DIV_STAGES+1];
	logic             sat_s[DIV_STAGES+1];
	srch_t            res_s[DIV_STAGES+1];
	logic [REM_W-1:0] rem_s[DIV_STAGES+1];
	logic [Q_W-1:0]   q_s[DIV_STAGES+1];
	logic [REM_W-1:0] num_c;

	assign num_c = REM_W'({in_res.dco, NUM_SHIFT'(0)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// quotient of 2^38 or more saturates; zero crystal lands here too
	always_ff @(posedge clk) begin
		if (en) begin
			res_s[0] <= in_res;
			sat_s[0] <= (num_c >= REM_W'(den));
			rem_s[0] <= (num_c >= REM_W'(den)) ? '0 : num_c;
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_st
		logic [REM_W-1:0] r_c;
		logic [Q_W-1:0]   q_c;

		always_comb begin
			r_c = rem_s[j-1];
			q_c = q_s[j-1];
			for (int b = 0; b < 2; b++) begin
				r_c = r_c << 1;
				q_c = q_c << 1;
				if (r_c >= REM_W'(den)) begin
					r_c    = r_c - REM_W'(den);
					q_c[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[j] <= res_s[j-1];
				sat_s[j] <= sat_s[j-1];
				rem_s[j] <= r_c;
				q_s[j]   <= q_c;
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_res   = res_s[DIV_STAGES];
	assign rfreq     = !res_s[DIV_STAGES].found ? '0 :
	                   sat_s[DIV_STAGES] ? '1 : q_s[DIV_STAGES];

endmodule

/* src/synth_divider_planner.sv */
// ----------------------------------------------------------------------------
// synth_divider_planner - DCO divider and RFREQ planner
// Picks HS/N1 dividers for a target frequency and computes the RFREQ word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    target_hz
//  rsp      out  valid/ready    found, hs_div_code, n1_code, dco_hz, rfreq
//  cfg      in   cfg_we         cfg_wdata (crystal, MHz 7.24)
//
//  One item per cycle while rsp is not stalled. The divider search registers
//  lane products, three shift-subtract stages and select; RFREQ registers a
//  check plus 19 stages of two quotient bits, the divider sets the depth.
//  arst_n clears all valid bits; the crystal returns to its calibrated value.
//  A stalled rsp freezes the whole pipe; req.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module synth_divider_planner import sdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [XTAL_W-1:0] cfg_wdata,
	sdp_req_if.sink           req,
	sdp_rsp_if.source         rsp
);

	logic             en;
	logic             srch_v, div_v;
	srch_t            srch_res, div_res;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   rfreq;

	// crystal kept as xtal * 1e6, the RFREQ denominator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= DEN_RESET;
		end else if (cfg_we) begin
			den_q <= DEN_W'(cfg_wdata) * XTAL_SCALE;
		end
	end

	// whole pipe moves when the output slot is free or being taken
	assign en        = !div_v || rsp.ready;
	assign req.ready = en;

	sdp_n1_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.target_hz (req.target_hz),
		.out_valid (srch_v),
		.res       (srch_res)
	);

	sdp_rfreq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (srch_v),
		.in_res    (srch_res),
		.den       (den_q),
		.out_valid (div_v),
		.out_res   (div_res),
		.rfreq     (rfreq)
	);

	assign rsp.valid       = div_v;
	assign rsp.found       = div_res.found;
	assign rsp.hs_div_code = div_res.code;
	assign rsp.n1_code     = div_res.n1_code;
	assign rsp.dco_hz      = div_res.dco;
	assign rsp.rfreq       = rfreq;

endmodule
